### rtl/gma_pkg.sv
// ----------------------------------------------------------------------------
// gma_pkg: shared types, constants and table builders
// Holds the item side record that travels along the cell chains, the status
// codes, the log2 interpolation table and the table of successive square
// roots of two that the exponent chain multiplies by.
// ----------------------------------------------------------------------------
package gma_pkg;

  localparam int LOG_TABLE_DEPTH = 256;
  localparam int LIDX_W = $clog2(LOG_TABLE_DEPTH + 1);
  localparam int POS_W = 32 + LIDX_W;

  localparam int SQ_W = 50;
  localparam int R_W = 25;
  localparam int K_W = 5;
  localparam int SQRT_STEPS = 25;
  localparam int NORM_STEPS = 5;
  localparam int EXP_STEPS = 24;

  localparam logic [1:0] ST_COMPUTED = 2'd0;
  localparam logic [1:0] ST_OFF = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  // Per-item record carried alongside the arithmetic of each chain.
  typedef struct packed {
    logic valid;
    logic mag_zero;
    logic r_zero;
    logic [15:0] mag;
    logic [15:0] alpha;
    logic [15:0] beta;
    logic [15:0] decay;
    logic [15:0] err;
    logic [R_W-1:0] r;
  } side_t;

  typedef logic [24:0] log_rom_t [LOG_TABLE_DEPTH+1];
  typedef logic [31:0] root_rom_t [EXP_STEPS+1];

  // Fraction of log2 of a Q.30 mantissa by repeated squaring, Q.24.
  function automatic logic [24:0] log2_mant(input logic [63:0] m_in);
    logic [63:0] m;
    logic [24:0] res;
    m = m_in;
    res = '0;
    for (int k = 0; k < 24; k++) begin
      m = (m * m) >> 30;
      res = {res[23:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        res[0] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      rom[i] = log2_mant(64'h4000_0000 + ((64'(i) << 30) / LOG_TABLE_DEPTH));
    end
    rom[LOG_TABLE_DEPTH] = 25'h100_0000;
    return rom;
  endfunction

  // Floor square root of a 64-bit value.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = v_in;
    res = '0;
    b = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic root_rom_t build_root_rom();
    root_rom_t rom;
    rom[0] = 32'h8000_0000;
    for (int k = 1; k <= EXP_STEPS; k++) begin
      rom[k] = 32'(isqrt64(64'(rom[k-1]) << 30));
    end
    return rom;
  endfunction

endpackage

### rtl/gma_sqrt_cell.sv
// ----------------------------------------------------------------------------
// gma_sqrt_cell: one result bit of the distance square root
// Restoring digit step: tries the bit, subtracts when it fits, and hands the
// remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module gma_sqrt_cell
  import gma_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [K_W-1:0]  k_i,
  input  side_t           side_i,
  input  logic [SQ_W-1:0] v_i,
  input  logic [SQ_W-1:0] res_i,
  output side_t           side_o,
  output logic [SQ_W-1:0] v_o,
  output logic [SQ_W-1:0] res_o
);

  logic [SQ_W-1:0] bit_w;
  logic [SQ_W-1:0] trial;
  logic            fits;
  logic [SQ_W-1:0] v_d, res_d;
  side_t           side_q;
  logic [SQ_W-1:0] v_q, res_q;

  // Trial subtraction for this bit position.
  always_comb begin
    bit_w = SQ_W'(1) << {k_i, 1'b0};
    trial = res_i + bit_w;
    fits = (v_i >= trial);
    v_d = fits ? (v_i - trial) : v_i;
    res_d = fits ? ((res_i >> 1) + bit_w) : (res_i >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      res_q <= res_d;
    end
  end

  assign side_o = side_q;
  assign v_o = v_q;
  assign res_o = res_q;

endmodule

### rtl/gma_norm_cell.sv
// ----------------------------------------------------------------------------
// gma_norm_cell: one step of the leading-one search on the root
// Shifts the root left by a fixed amount when its top bits are all zero and
// lowers the exponent to match.
// ----------------------------------------------------------------------------
module gma_norm_cell
  import gma_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [K_W-1:0] sh_i,
  input  side_t          side_i,
  input  logic [R_W-1:0] m_i,
  input  logic [K_W-1:0] p_i,
  output side_t          side_o,
  output logic [R_W-1:0] m_o,
  output logic [K_W-1:0] p_o
);

  logic [R_W-1:0] top_mask;
  logic           top_clear;
  logic [R_W-1:0] m_d;
  logic [K_W-1:0] p_d;
  side_t          side_q;
  logic [R_W-1:0] m_q;
  logic [K_W-1:0] p_q;

  // Shift when the top bits of this step's width hold no set bit.
  always_comb begin
    top_mask = ~({R_W{1'b1}} >> sh_i);
    top_clear = ((m_i & top_mask) == '0);
    m_d = top_clear ? (m_i << sh_i) : m_i;
    p_d = top_clear ? (p_i - sh_i) : p_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q <= m_d;
      p_q <= p_d;
    end
  end

  assign side_o = side_q;
  assign m_o = m_q;
  assign p_o = p_q;

endmodule

### rtl/gma_exp_cell.sv
// ----------------------------------------------------------------------------
// gma_exp_cell: one fraction bit of the power-of-two evaluation
// Multiplies the running Q.30 product by this bit's root of two when the
// fraction bit is set, flooring back to Q.30.
// ----------------------------------------------------------------------------
module gma_exp_cell
  import gma_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [K_W-1:0] bit_i,
  input  logic [31:0]    root_i,
  input  side_t          side_i,
  input  logic [8:0]     n_i,
  input  logic [23:0]    f_i,
  input  logic [31:0]    p_i,
  output side_t          side_o,
  output logic [8:0]     n_o,
  output logic [23:0]    f_o,
  output logic [31:0]    p_o
);

  logic [63:0] prod;
  logic [31:0] p_d;
  side_t       side_q;
  logic [8:0]  n_q;
  logic [23:0] f_q;
  logic [31:0] p_q;

  // Conditional multiply by the root for this bit.
  always_comb begin
    prod = 64'(p_i) * 64'(root_i);
    p_d = f_i[bit_i] ? prod[61:30] : p_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_i;
      f_q <= f_i;
      p_q <= p_d;
    end
  end

  assign side_o = side_q;
  assign n_o = n_q;
  assign f_o = f_q;
  assign p_o = p_q;

endmodule

### rtl/ground_motion_attenuation_pga_top.sv
// ----------------------------------------------------------------------------
// ground_motion_attenuation_pga_top: peak ground acceleration attenuation
// An accepted item passes one input stage, 25 square-root cells,
// 5 normalize cells, 9 log and sum stages, 24 exponent cells and the
// output register on its way to the result.
// Throughput is one item per cycle; the whole chain holds only while a
// result waits and the output is stalled.
// Reset clears every valid flag; the tables are constants and need no fill.
// ----------------------------------------------------------------------------
module ground_motion_attenuation_pga_top
  import gma_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] magnitude_i,
  input  logic [15:0] alpha_factor_i,
  input  logic [15:0] beta_factor_i,
  input  logic [15:0] decay_factor_i,
  input  logic [15:0] error_term_i,
  input  logic [23:0] surface_distance_i,
  input  logic [15:0] source_altitude_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pga_o,
  output logic [1:0]  status_o
);

  localparam int S_W = 52;
  localparam log_rom_t LOG_ROM = build_log_rom();
  localparam root_rom_t ROOT_ROM = build_root_rom();
  localparam logic signed [25:0] C_ALPHA = -26'sd17112760;
  localparam logic signed [23:0] C_BETA = 24'sd4177527;
  localparam logic signed [16:0] C_DECAY = -17'sd42782;
  localparam logic signed [23:0] C_ERR = 24'sd4362076;
  localparam logic signed [27:0] LOG10_OF_2 = 28'sd80807124;
  localparam logic signed [30:0] LOG2_OF_10 = 31'sd891723283;
  localparam logic signed [30:0] EIGHT_Q24 = 31'sd134217728;
  localparam logic signed [S_W-1:0] L_MAX = S_W'(268435456);
  localparam logic signed [S_W-1:0] L_MIN = S_W'(-268435456);

  logic adv;

  // The chain moves whenever the output register can take a new result.
  assign adv = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Input stage: side record and the sum of squared distances.
  logic [15:0]     h_abs;
  logic [47:0]     d_sq;
  logic [31:0]     h_sq;
  side_t           in_side_d, in_side_q;
  logic [SQ_W-1:0] in_v_q;

  always_comb begin
    h_abs = source_altitude_i[15] ? 16'(-$signed(source_altitude_i)) : source_altitude_i;
    d_sq = 48'(surface_distance_i) * 48'(surface_distance_i);
    h_sq = 32'(h_abs) * 32'(h_abs);
    in_side_d.valid = in_valid_i;
    in_side_d.mag_zero = (magnitude_i == '0);
    in_side_d.r_zero = 1'b0;
    in_side_d.mag = magnitude_i;
    in_side_d.alpha = alpha_factor_i;
    in_side_d.beta = beta_factor_i;
    in_side_d.decay = decay_factor_i;
    in_side_d.err = error_term_i;
    in_side_d.r = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_side_q <= '0;
    end else if (adv) begin
      in_side_q <= in_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_v_q <= SQ_W'(d_sq) + SQ_W'(h_sq);
    end
  end

  // Square-root chain, most significant result bit first.
  side_t           sq_side [SQRT_STEPS+1];
  logic [SQ_W-1:0] sq_v [SQRT_STEPS+1];
  logic [SQ_W-1:0] sq_res [SQRT_STEPS+1];

  assign sq_side[0] = in_side_q;
  assign sq_v[0] = in_v_q;
  assign sq_res[0] = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    gma_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .k_i    (K_W'(SQRT_STEPS - 1 - g)),
      .side_i (sq_side[g]),
      .v_i    (sq_v[g]),
      .res_i  (sq_res[g]),
      .side_o (sq_side[g+1]),
      .v_o    (sq_v[g+1]),
      .res_o  (sq_res[g+1])
    );
  end

  // Normalize chain: find the leading one of the root.
  side_t          nm_side [NORM_STEPS+1];
  logic [R_W-1:0] nm_m [NORM_STEPS+1];
  logic [K_W-1:0] nm_p [NORM_STEPS+1];

  always_comb begin
    nm_side[0] = sq_side[SQRT_STEPS];
    nm_side[0].r = sq_res[SQRT_STEPS][R_W-1:0];
    nm_side[0].r_zero = (sq_res[SQRT_STEPS] == '0);
    nm_m[0] = sq_res[SQRT_STEPS][R_W-1:0];
    nm_p[0] = K_W'(R_W - 1);
  end

  for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
    gma_norm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .sh_i   (K_W'(1 << (NORM_STEPS - 1 - g))),
      .side_i (nm_side[g]),
      .m_i    (nm_m[g]),
      .p_i    (nm_p[g]),
      .side_o (nm_side[g+1]),
      .m_o    (nm_m[g+1]),
      .p_o    (nm_p[g+1])
    );
  end

  // Log and sum stages.
  side_t                   ls_q [1:8];
  logic [POS_W-1:0]        pos_q;
  logic [K_W-1:0]          p1_q, p2_q, p3_q;
  logic signed [32:0]      bm_q;
  logic signed [41:0]      cr_q;
  logic signed [41:0]      ta_q, ta2_q;
  logic signed [39:0]      te_q, te2_q;
  logic [24:0]             lo2_q, lo3_q, diff2_q;
  logic [31:0]             w2_q;
  logic signed [56:0]      bmc_q;
  logic signed [58:0]      crc_q;
  logic [56:0]             dw_q;
  logic signed [S_W-1:0]   s1_q, s1b_q, s1c_q;
  logic [29:0]             lg2_q;
  logic signed [58:0]      lgp_q;
  logic signed [S_W-1:0]   sum_q;
  logic signed [29:0]      lv_q;
  logic signed [60:0]      yp_q;
  logic [LIDX_W-1:0]       idx, idx_n;
  logic signed [S_W-1:0]   lg10_ext;
  logic signed [S_W-1:0]   lval;
  logic signed [29:0]      lv_d;
  logic signed [30:0]      lgd;
  logic signed [32:0]      y;
  logic [8:0]              ex_n0;

  // Table addressing, clamp and split of the base-two exponent.
  always_comb begin
    idx = pos_q[POS_W-1:32];
    idx_n = idx + LIDX_W'(1);
    lgd = $signed({1'b0, lg2_q}) - EIGHT_Q24;
    lg10_ext = S_W'(lgp_q >>> 28);
    lval = sum_q >>> 12;
    if (lval > L_MAX) begin
      lv_d = 30'(L_MAX);
    end else if (lval < L_MIN) begin
      lv_d = 30'(L_MIN);
    end else begin
      lv_d = 30'(lval);
    end
    y = 33'(yp_q >>> 28);
    ex_n0 = 9'(y >>> 24);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= 8; i++) begin
        ls_q[i] <= '0;
      end
    end else if (adv) begin
      ls_q[1] <= nm_side[NORM_STEPS];
      for (int i = 2; i <= 8; i++) begin
        ls_q[i] <= ls_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Table position and the factor products.
      pos_q <= POS_W'({nm_m[NORM_STEPS][23:0], 8'b0}) * POS_W'(LOG_TABLE_DEPTH);
      p1_q <= nm_p[NORM_STEPS];
      bm_q <= $signed(nm_side[NORM_STEPS].beta) * $signed({1'b0, nm_side[NORM_STEPS].mag});
      cr_q <= $signed(nm_side[NORM_STEPS].decay) * $signed({1'b0, nm_side[NORM_STEPS].r});
      ta_q <= C_ALPHA * $signed(nm_side[NORM_STEPS].alpha);
      te_q <= C_ERR * $signed(nm_side[NORM_STEPS].err);
      // Table reads and constant scaling.
      lo2_q <= LOG_ROM[idx];
      diff2_q <= LOG_ROM[idx_n] - LOG_ROM[idx];
      w2_q <= pos_q[31:0];
      p2_q <= p1_q;
      bmc_q <= bm_q * C_BETA;
      crc_q <= cr_q * C_DECAY;
      ta2_q <= ta_q;
      te2_q <= te_q;
      // Interpolation product and the sum of the factor terms.
      dw_q <= 57'(diff2_q) * 57'(w2_q);
      lo3_q <= lo2_q;
      p3_q <= p2_q;
      s1_q <= S_W'(ta2_q) + S_W'(bmc_q >>> 12) + S_W'(crc_q >>> 8) + S_W'(te2_q);
      // log2 of the distance.
      lg2_q <= 30'({p3_q, 24'b0}) + 30'(lo3_q) + 30'(dw_q >> 32);
      s1b_q <= s1_q;
      // Change of base to log10.
      lgp_q <= lgd * LOG10_OF_2;
      s1c_q <= s1b_q;
      sum_q <= s1c_q - (lg10_ext <<< 12);
      lv_q <= lv_d;
      yp_q <= lv_q * LOG2_OF_10;
    end
  end

  // Exponent chain over the fraction bits, most significant first.
  side_t       ex_side [EXP_STEPS+1];
  logic [8:0]  ex_n [EXP_STEPS+1];
  logic [23:0] ex_f [EXP_STEPS+1];
  logic [31:0] ex_p [EXP_STEPS+1];
  side_t       ex_side0_q;
  logic [8:0]  ex_n0_q;
  logic [23:0] ex_f0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_side0_q <= '0;
    end else if (adv) begin
      ex_side0_q <= ls_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex_n0_q <= ex_n0;
      ex_f0_q <= y[23:0];
    end
  end

  assign ex_side[0] = ex_side0_q;
  assign ex_n[0] = ex_n0_q;
  assign ex_f[0] = ex_f0_q;
  assign ex_p[0] = 32'h4000_0000;

  for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp
    gma_exp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .bit_i  (K_W'(EXP_STEPS - 1 - g)),
      .root_i (ROOT_ROM[g+1]),
      .side_i (ex_side[g]),
      .n_i    (ex_n[g]),
      .f_i    (ex_f[g]),
      .p_i    (ex_p[g]),
      .side_o (ex_side[g+1]),
      .n_o    (ex_n[g+1]),
      .f_o    (ex_f[g+1]),
      .p_o    (ex_p[g+1])
    );
  end

  // Final scaling, special cases and saturation.
  logic signed [9:0] sh;
  logic [9:0]        amt;
  logic [33:0]       up;
  logic [31:0]       pga_d;
  logic [1:0]        status_d;
  logic              out_valid_q;
  logic [31:0]       pga_q;
  logic [1:0]        status_q;

  always_comb begin
    sh = 10'($signed(ex_n[EXP_STEPS])) - 10'sd2;
    amt = 10'(-sh);
    up = {2'b0, ex_p[EXP_STEPS]} << sh[1:0];
    pga_d = '0;
    status_d = ST_COMPUTED;
    if (ex_side[EXP_STEPS].mag_zero) begin
      status_d = ST_OFF;
    end else if (ex_side[EXP_STEPS].r_zero || sh >= 10'sd3) begin
      pga_d = '1;
      status_d = ST_SAT;
    end else if (sh >= 10'sd0) begin
      if (up[33:32] != 2'b00) begin
        pga_d = '1;
        status_d = ST_SAT;
      end else begin
        pga_d = up[31:0];
      end
    end else if (amt < 10'd32) begin
      pga_d = ex_p[EXP_STEPS] >> amt[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ex_side[EXP_STEPS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pga_q <= pga_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pga_o = pga_q;
  assign status_o = status_q;

  // The chain only holds while a result is waiting on a stalled output.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // A finished item at the chain end reaches the output register.
  a_chain_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_side[EXP_STEPS].valid && !in_stall_o |=> out_valid_o)
    else $error("item lost between exponent chain and output");

  // Saturated results carry the full-scale value.
  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SAT |-> pga_o == 32'hFFFF_FFFF)
    else $error("saturated status without full-scale value");

  // A zero magnitude gives a zero acceleration.
  a_off_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OFF |-> pga_o == 32'h0)
    else $error("off status with nonzero value");

endmodule
